[src/itp_pkg.sv]
// itp_pkg: shared types and constants of the infix to postfix converter
// token mode codes, error codes and the layout of one operator stack entry
// no dependencies
package itp_pkg;

    localparam int DEF_STACK_DEPTH = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int PAY_W           = 32;
    localparam int PREC_W          = 8;

    localparam logic [2:0] MODE_NUM    = 3'd0;
    localparam logic [2:0] MODE_OP     = 3'd1;
    localparam logic [2:0] MODE_LPAREN = 3'd2;
    localparam logic [2:0] MODE_RPAREN = 3'd3;
    localparam logic [2:0] MODE_END    = 3'd4;

    localparam logic KIND_NUM = 1'b0;
    localparam logic KIND_OP  = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_RPAREN   = 2'd2;
    localparam logic [1:0] ERR_LPAREN   = 2'd3;

    typedef struct packed {
        logic              lparen;
        logic [PREC_W-1:0] prec;
        logic [PAY_W-1:0]  payload;
    } t_entry;

endpackage

[src/infix_to_postfix_converter_top.sv]
// infix_to_postfix_converter_top: shunting-yard converter, infix words in, postfix words out
// a word is taken only in S_IDLE; numbers go via the pending register to the output register
// after S_IDLE: S_FIN for a number, rparen or end; S_PUSH, S_FIN for an operator or lparen,
// plus S_RD and S_EV per stack read (one memory read each); S_EV, S_FIN wait while held off
// reset clears the stack pointer and the control state; stack memory is not cleared
// depends on itp_pkg and itp_stack
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2:0]                i_mode,
    input  logic [itp_pkg::PAY_W-1:0] i_payload,
    input  logic [itp_pkg::PREC_W-1:0] i_precedence,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_token_kind,
    output logic [itp_pkg::PAY_W-1:0] o_token_payload,
    output logic                      o_last_of_run,
    output logic [1:0]                o_error_code
);
    import itp_pkg::*;

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_PUSH, S_FIN} t_state;

    t_state             r_state, n_state;
    logic [SPW-1:0]     r_sp, n_sp;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [2:0]         r_mode, n_mode;
    logic [PAY_W-1:0]   r_pay, n_pay;
    logic [PREC_W-1:0]  r_prec, n_prec;
    logic [1:0]         r_err, n_err;
    logic               r_pend_v, n_pend_v;
    logic               r_pend_kind, n_pend_kind;
    logic [PAY_W-1:0]   r_pend_pay, n_pend_pay;
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [PAY_W-1:0]   r_out_pay, n_out_pay;
    logic               r_out_last, n_out_last;
    logic [1:0]         r_out_err, n_out_err;

    logic               w_slot;
    logic               w_can_emit;
    logic [SPW-1:0]     w_sp_dec;
    logic [CW-1:0]      w_cnt_inc;
    logic               w_more;
    logic               w_we;
    t_entry             w_wdata;
    t_entry             w_e;
    logic [AW-1:0]      w_raddr;

    assign w_sp_dec  = r_sp - 1'b1;
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_raddr   = w_sp_dec[AW-1:0];
    assign w_slot    = !r_out_valid || i_ready;
    assign w_can_emit = !r_pend_v || w_slot;
    assign w_more    = (w_sp_dec != '0) && (w_cnt_inc < CW'(MAX_RESULTS));

    assign w_wdata.lparen  = (r_mode == MODE_LPAREN);
    assign w_wdata.prec    = (r_mode == MODE_LPAREN) ? '0 : r_prec;
    assign w_wdata.payload = r_pay;

    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .AW         (AW)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_sp[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_e)
    );

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_pay       = r_pay;
        n_prec      = r_prec;
        n_err       = r_err;
        n_pend_v    = r_pend_v;
        n_pend_kind = r_pend_kind;
        n_pend_pay  = r_pend_pay;
        n_out_valid = r_out_valid && !i_ready;
        n_out_kind  = r_out_kind;
        n_out_pay   = r_out_pay;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        w_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode = i_mode;
                    n_pay  = i_payload;
                    n_prec = i_precedence;
                    n_cnt  = '0;
                    n_err  = ERR_NONE;
                    case (i_mode)
                        MODE_NUM: begin
                            n_pend_v    = 1'b1;
                            n_pend_kind = KIND_NUM;
                            n_pend_pay  = i_payload;
                            n_state     = S_FIN;
                        end
                        MODE_OP: begin
                            n_state = (r_sp != '0) ? S_RD : S_PUSH;
                        end
                        MODE_LPAREN: begin
                            n_state = S_PUSH;
                        end
                        MODE_RPAREN: begin
                            if (r_sp != '0) begin
                                n_state = S_RD;
                            end else begin
                                n_err   = ERR_RPAREN;
                                n_state = S_FIN;
                            end
                        end
                        MODE_END: begin
                            n_state = (r_sp != '0) ? S_RD : S_FIN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (r_mode == MODE_OP && (w_e.lparen || w_e.prec < r_prec)) begin
                    n_state = S_PUSH;
                end else if (w_e.lparen && r_mode != MODE_OP) begin
                    n_sp = w_sp_dec;
                    if (r_mode == MODE_END) begin
                        n_err   = ERR_LPAREN;
                        n_state = ((w_sp_dec != '0) && (r_cnt < CW'(MAX_RESULTS))) ?
                                  S_RD : S_FIN;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (w_can_emit) begin
                    // pending word moves out, popped operator becomes pending
                    if (r_pend_v) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = r_pend_kind;
                        n_out_pay   = r_pend_pay;
                        n_out_last  = 1'b0;
                        n_out_err   = ERR_NONE;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_kind = KIND_OP;
                    n_pend_pay  = w_e.payload;
                    n_sp        = w_sp_dec;
                    n_cnt       = w_cnt_inc;
                    case (r_mode)
                        MODE_OP: begin
                            n_state = w_more ? S_RD : S_PUSH;
                        end
                        MODE_RPAREN: begin
                            if (w_more) begin
                                n_state = S_RD;
                            end else begin
                                if (w_sp_dec == '0) begin
                                    n_err = ERR_RPAREN;
                                end
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = w_more ? S_RD : S_FIN;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                if (r_sp >= SPW'(STACK_DEPTH)) begin
                    n_err = ERR_OVERFLOW;
                end else begin
                    w_we = 1'b1;
                    n_sp = r_sp + 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_pend_v) begin
                    if (w_slot) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = r_pend_kind;
                        n_out_pay   = r_pend_pay;
                        n_out_last  = 1'b1;
                        n_out_err   = r_err;
                        n_pend_v    = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else if (r_err != ERR_NONE) begin
                    if (w_slot) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_NUM;
                        n_out_pay   = '0;
                        n_out_last  = 1'b1;
                        n_out_err   = r_err;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_cnt       <= n_cnt;
        r_mode      <= n_mode;
        r_pay       <= n_pay;
        r_prec      <= n_prec;
        r_err       <= n_err;
        r_pend_kind <= n_pend_kind;
        r_pend_pay  <= n_pend_pay;
        r_out_kind  <= n_out_kind;
        r_out_pay   <= n_out_pay;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_token_kind    = r_out_kind;
    assign o_token_payload = r_out_pay;
    assign o_last_of_run   = r_out_last;
    assign o_error_code    = r_out_err;

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_sp < SPW'(STACK_DEPTH)))
        else $error("push into full stack");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != ERR_NONE) |-> o_last_of_run)
        else $error("error code on a word that is not last");

    a_successor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> r_pend_v)
        else $error("non-final word without a pending successor");

endmodule

[src/itp_stack.sv]
// itp_stack: operator stack storage, one write port and one registered read port
// depends on itp_pkg for the entry layout
module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH,
    parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  itp_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output itp_pkg::t_entry o_rdata
);
    import itp_pkg::*;

    t_entry r_mem [STACK_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
